// ===== rtl/pdm_to_pcm_fir_decimator_unit_assert.svh =====
// Assertion macros for the PDM to PCM FIR decimator.
// Expects signals named clk and rst_n in the including scope.
`ifndef PDM_TO_PCM_FIR_DECIMATOR_UNIT_ASSERT_SVH
`define PDM_TO_PCM_FIR_DECIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PDMFIR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDMFIR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdmfir_pkg.sv =====
// Package for the PDM to PCM FIR decimator: sizes, codes and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
package pdmfir_pkg;

    localparam int TAPS       = 256;
    localparam int DECIMATION = 64;
    localparam int COEF_WIDTH = 16;

    localparam int WORD_BITS   = 16;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_IDX_W  = 8;
    localparam int COEF_VAL_W  = 16;
    localparam int PCM_W       = 24;
    localparam int SHIFT_W     = 5;

    localparam int TAP_AW      = $clog2(TAPS);
    localparam int MAC_CNT_W   = $clog2(TAPS + 2);
    localparam int BIT_CNT_W   = $clog2(WORD_BITS + 1);
    localparam int PHASE_W     = $clog2(DECIMATION);
    localparam int PROD_W      = COEF_WIDTH + SAMPLE_W;
    localparam int ACC_W       = PROD_W + $clog2(TAPS);

    localparam logic FUNC_COEF = 1'b0;
    localparam logic FUNC_PDM  = 1'b1;

    localparam logic [SHIFT_W-1:0] OUTPUT_SHIFT_RESET = SHIFT_W'(15);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_HIGH = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LOW  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NONE = '0;

    localparam logic signed [PCM_W-1:0] PCM_MAX = 24'sh7FFFFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN = 24'sh800000;
    localparam logic signed [ACC_W-1:0] PCM_MAX_ACC = ACC_W'(PCM_MAX);
    localparam logic signed [ACC_W-1:0] PCM_MIN_ACC = ACC_W'(PCM_MIN);

    typedef struct packed {
        logic              coef_we;
        logic              load_word;
        logic              shift_bit;
        logic              acc_clear;
        logic              mac_issue;
        logic [TAP_AW-1:0] mac_addr;
        logic              load_result;
    } pdmfir_cmd_t;

    typedef struct packed {
        logic out_busy;
    } pdmfir_sts_t;

endpackage

// ===== rtl/pdmfir_if.sv =====
// Channel interfaces of the PDM to PCM FIR decimator: the input item
// channel and the result channel. Depends on pdmfir_pkg.
interface pdmfir_in_if import pdmfir_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_VAL_W-1:0] coef_value;
    logic [WORD_BITS-1:0]         pdm_word;

    modport source (output valid, func, coef_index, coef_value, pdm_word, input ready);
    modport sink   (input valid, func, coef_index, coef_value, pdm_word, output ready);
endinterface

interface pdmfir_out_if import pdmfir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    saturated;

    modport source (output valid, pcm_sample, saturated, input ready);
    modport sink   (input valid, pcm_sample, saturated, output ready);
endinterface

// ===== rtl/pdmfir_ctrl.sv =====
// Controller of the PDM to PCM FIR decimator: sequences bit shifts,
// the multiply-accumulate sweep and result hand-off. Depends on pdmfir_pkg.
module pdmfir_ctrl
    import pdmfir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_func,
    output logic        in_ready,
    input  pdmfir_sts_t sts,
    output pdmfir_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_MAC,
        S_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bits_reg, bits_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [MAC_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BIT_CNT_W-1:0]   bits_inc;
    logic [PHASE_W:0]       phase_inc;

    assign bits_inc  = bits_reg + BIT_CNT_W'(1);
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W + 1)'(1);
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_PDM)
                    begin
                        cmd.load_word = 1'b1;
                        bits_next     = '0;
                        state_next    = S_BITS;
                    end
                    else
                    begin
                        cmd.coef_we = 1'b1;
                    end
                end
            end
            S_BITS:
            begin
                cmd.shift_bit = 1'b1;
                bits_next     = bits_inc;
                if (phase_inc == (PHASE_W + 1)'(DECIMATION))
                begin
                    phase_next = '0;
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    phase_next = phase_inc[PHASE_W-1:0];
                    if (bits_inc == BIT_CNT_W'(WORD_BITS))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MAC:
            begin
                if (cnt_reg < MAC_CNT_W'(TAPS))
                begin
                    cmd.mac_issue = 1'b1;
                    cmd.mac_addr  = cnt_reg[TAP_AW-1:0];
                end
                if (cnt_reg == '0)
                begin
                    cmd.acc_clear = 1'b1;
                end
                if (cnt_reg == MAC_CNT_W'(TAPS + 1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + MAC_CNT_W'(1);
                end
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next = (bits_reg == BIT_CNT_W'(WORD_BITS)) ? S_IDLE : S_BITS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bits_reg  <= '0;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg  <= bits_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/pdmfir_dp.sv =====
// Datapath of the PDM to PCM FIR decimator: coefficient memory, bit delay
// line, multiply-accumulate pipeline and output register. Depends on pdmfir_pkg.
module pdmfir_dp
    import pdmfir_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [SHIFT_W-1:0]           cfg_wdata,
    input  logic [COEF_IDX_W-1:0]        coef_index,
    input  logic signed [COEF_VAL_W-1:0] coef_value,
    input  logic [WORD_BITS-1:0]         pdm_word,
    input  pdmfir_cmd_t                  cmd,
    output pdmfir_sts_t                  sts,
    pdmfir_out_if.source                 pcm
);

    logic signed [COEF_WIDTH-1:0] coef_mem [TAPS];
    logic signed [COEF_WIDTH-1:0] coef_rd_reg;
    logic signed [COEF_WIDTH-1:0] coef_wrapped;
    logic                         coef_in_range;

    logic [SHIFT_W-1:0]   shift_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [TAPS-1:0]      line_bit_reg;
    logic [TAPS-1:0]      line_vld_reg;
    logic                 tap_bit_reg;
    logic                 tap_vld_reg;
    logic                 stage1_vld_reg;
    logic                 stage2_vld_reg;

    logic signed [SAMPLE_W-1:0] tap_sample;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_shifted;
    logic signed [PCM_W-1:0]    pcm_next;
    logic                       sat_next;

    logic                    out_valid_reg;
    logic signed [PCM_W-1:0] pcm_reg;
    logic                    sat_reg;

    assign coef_wrapped  = COEF_WIDTH'(coef_value);
    assign coef_in_range = 32'(coef_index) < 32'(TAPS);

    always_ff @(posedge clk)
    begin
        if (cmd.coef_we && coef_in_range)
        begin
            coef_mem[TAP_AW'(coef_index)] <= coef_wrapped;
        end
        if (cmd.mac_issue)
        begin
            coef_rd_reg <= coef_mem[cmd.mac_addr];
        end
    end

    // The line holds only the PDM bit of each sample; index TAPS-1 is the oldest.
    // A MAC sweep rotates the line once around, presenting each tap in turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= OUTPUT_SHIFT_RESET;
            line_vld_reg   <= '0;
            stage1_vld_reg <= 1'b0;
            stage2_vld_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                shift_reg <= cfg_wdata;
            end
            if (cmd.shift_bit)
            begin
                line_vld_reg <= {line_vld_reg[TAPS-2:0], 1'b1};
            end
            else if (cmd.mac_issue)
            begin
                line_vld_reg <= {line_vld_reg[TAPS-2:0], line_vld_reg[TAPS-1]};
            end
            stage1_vld_reg <= cmd.mac_issue;
            stage2_vld_reg <= stage1_vld_reg;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pcm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            word_reg <= pdm_word;
        end
        else if (cmd.shift_bit)
        begin
            word_reg <= {word_reg[WORD_BITS-2:0], 1'b0};
        end
        if (cmd.shift_bit)
        begin
            line_bit_reg <= {line_bit_reg[TAPS-2:0], word_reg[WORD_BITS-1]};
        end
        else if (cmd.mac_issue)
        begin
            line_bit_reg <= {line_bit_reg[TAPS-2:0], line_bit_reg[TAPS-1]};
        end
        if (cmd.mac_issue)
        begin
            tap_bit_reg <= line_bit_reg[TAPS-1];
            tap_vld_reg <= line_vld_reg[TAPS-1];
        end
        prod_reg <= coef_rd_reg * tap_sample;
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (stage2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.load_result)
        begin
            pcm_reg <= pcm_next;
            sat_reg <= sat_next;
        end
    end

    assign tap_sample = !tap_vld_reg ? SAMPLE_NONE : (tap_bit_reg ? SAMPLE_HIGH : SAMPLE_LOW);

    assign acc_shifted = acc_reg >>> shift_reg;

    always_comb
    begin
        if (acc_shifted > PCM_MAX_ACC)
        begin
            pcm_next = PCM_MAX;
            sat_next = 1'b1;
        end
        else if (acc_shifted < PCM_MIN_ACC)
        begin
            pcm_next = PCM_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            pcm_next = acc_shifted[PCM_W-1:0];
            sat_next = 1'b0;
        end
    end

    assign sts.out_busy   = out_valid_reg && !pcm.ready;
    assign pcm.valid      = out_valid_reg;
    assign pcm.pcm_sample = pcm_reg;
    assign pcm.saturated  = sat_reg;

endmodule

// ===== rtl/pdm_to_pcm_fir_decimator_unit.sv =====
// Top level of the PDM to PCM FIR decimator: controller, datapath and checks.
// Depends on pdmfir_pkg, pdmfir_if, pdmfir_ctrl, pdmfir_dp and the assertion header.
// A PDM word is accepted in S_IDLE; its bits then shift into the delay line one by one in
// S_BITS before ready returns. A word that completes a decimation group adds the serial
// multiply-accumulate sweep, one tap per cycle through the coefficient memory port.
// Reset clears control, delay line valid flags and output_shift (to 15), not the coefficients.
module pdm_to_pcm_fir_decimator_unit
    import pdmfir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata,
    pdmfir_in_if.sink          pdm,
    pdmfir_out_if.source       pcm
);

    pdmfir_cmd_t ctrl_cmd;
    pdmfir_sts_t dp_sts;
    logic        ctrl_in_ready;

    assign pdm.ready = ctrl_in_ready;

    pdmfir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pdm.valid),
        .in_func  (pdm.func),
        .in_ready (ctrl_in_ready),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    pdmfir_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .coef_index (pdm.coef_index),
        .coef_value (pdm.coef_value),
        .pdm_word   (pdm.pdm_word),
        .cmd        (ctrl_cmd),
        .sts        (dp_sts),
        .pcm        (pcm)
    );

`include "pdm_to_pcm_fir_decimator_unit_assert.svh"

    `PDMFIR_ASSERT_IMP(a_result_no_overwrite, ctrl_cmd.load_result, !pcm.valid || pcm.ready, "result loaded over a pending transfer")
    `PDMFIR_ASSERT_NEXT(a_word_busy, pdm.valid && pdm.ready && pdm.func == FUNC_PDM, !pdm.ready, "ready after a PDM word transfer")
    `PDMFIR_ASSERT_IMP(a_sat_at_limit, pcm.valid && pcm.saturated, pcm.pcm_sample == PCM_MAX || pcm.pcm_sample == PCM_MIN, "saturated sample not at a limit")

endmodule
